>>> sv/wlf_pkg.sv
// types and constants shared by the weight limited fifo modules
`default_nettype none

package wlf_pkg;

    localparam int CNT_W   = 5;
    localparam int MASS_W  = 16;
    localparam int SRC_W   = 16;
    localparam int WT_W    = 24;
    localparam int ITEM_W  = MASS_W + SRC_W;
    localparam int CFG_A_W = 2;

    localparam logic [CFG_A_W-1:0] CFG_SLOTS    = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_WT_LIMIT = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_CAPACITY = 2'd2;

    localparam logic [CNT_W-1:0] SLOTS_RST    = 5'd16;
    localparam logic [WT_W-1:0]  WT_LIMIT_RST = 24'hFFFFFF;
    localparam logic [WT_W-1:0]  CAPACITY_RST = 24'hFFFFFF;

    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_TAKE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_REFUSED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_OVERSIZE = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_full;
    } dp_sts_t;

endpackage

`default_nettype wire

>>> sv/wlf_ctrl.sv
// request sequencing state machine
`default_nettype none

module wlf_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire wlf_pkg::dp_sts_t   sts,
    output wlf_pkg::ctrl_cmd_t      cmd
);

    wlf_pkg::ctrl_state_t state_reg;
    wlf_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wlf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        unique case (state_reg)
            wlf_pkg::S_IDLE:
            begin
                in_ready    = !sts.out_full;
                cmd.capture = in_valid && !sts.out_full;
                if (in_valid && !sts.out_full)
                begin
                    state_next = wlf_pkg::S_EXEC;
                end
            end
            wlf_pkg::S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = wlf_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/wlf_dp.sv
// item store, occupancy and budget datapath with result register
`default_nettype none

module wlf_dp #(
    parameter int DEPTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire wlf_pkg::ctrl_cmd_t            cmd,
    output wlf_pkg::dp_sts_t                   sts,
    input  wire logic                          kind,
    input  wire logic [wlf_pkg::MASS_W-1:0]    item_mass,
    input  wire logic [wlf_pkg::SRC_W-1:0]     source_id,
    input  wire logic                          cfg_write_en,
    input  wire logic [wlf_pkg::CFG_A_W-1:0]   cfg_index,
    input  wire logic [wlf_pkg::WT_W-1:0]      cfg_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         status,
    output logic                               budget_refilled,
    output logic [wlf_pkg::MASS_W-1:0]         out_mass,
    output logic [wlf_pkg::SRC_W-1:0]          out_source,
    output logic [wlf_pkg::WT_W-1:0]           budget_left,
    output logic [wlf_pkg::CNT_W-1:0]          items_held,
    output logic [wlf_pkg::WT_W-1:0]           mass_held
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [wlf_pkg::ITEM_W-1:0] mem [DEPTH];
    logic [wlf_pkg::ITEM_W-1:0] rd_data_reg;

    logic [PW-1:0]               head_reg, head_next;
    logic [PW-1:0]               tail_reg, tail_next;
    logic [wlf_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [wlf_pkg::WT_W-1:0]    belt_reg, belt_next;
    logic [wlf_pkg::WT_W-1:0]    budget_reg, budget_next;

    logic [wlf_pkg::CNT_W-1:0]   slots_reg;
    logic [wlf_pkg::WT_W-1:0]    limit_reg;
    logic [wlf_pkg::WT_W-1:0]    cap_reg;

    logic                        kind_reg;
    logic [wlf_pkg::MASS_W-1:0]  mass_reg;
    logic [wlf_pkg::SRC_W-1:0]   src_reg;

    logic                        out_valid_reg;
    wlf_pkg::status_t            status_reg, status_next;
    logic                        refilled_reg, refilled_next;
    logic [wlf_pkg::MASS_W-1:0]  omass_reg, omass_next;
    logic [wlf_pkg::SRC_W-1:0]   osrc_reg, osrc_next;

    logic [wlf_pkg::CNT_W-1:0]   ring;
    logic [PW:0]                 head_inc, tail_inc;
    logic [PW-1:0]               head_adv, tail_adv;
    logic [wlf_pkg::WT_W:0]      put_sum;
    logic [wlf_pkg::MASS_W-1:0]  head_mass;
    logic [wlf_pkg::WT_W-1:0]    base_budget;
    logic                        mem_we;

    // effective ring size, clamped to one..DEPTH
    always_comb
    begin
        priority if (slots_reg == '0)
        begin
            ring = wlf_pkg::CNT_W'(1);
        end
        else if (32'(slots_reg) > DEPTH)
        begin
            ring = wlf_pkg::CNT_W'(DEPTH);
        end
        else
        begin
            ring = slots_reg;
        end
    end

    assign head_inc  = {1'b0, head_reg} + (PW+1)'(1);
    assign tail_inc  = {1'b0, tail_reg} + (PW+1)'(1);
    assign head_adv  = (32'(head_inc) >= 32'(ring)) ? '0 : head_inc[PW-1:0];
    assign tail_adv  = (32'(tail_inc) >= 32'(ring)) ? '0 : tail_inc[PW-1:0];
    assign put_sum   = {1'b0, belt_reg} + (wlf_pkg::WT_W+1)'(mass_reg);
    assign head_mass = rd_data_reg[wlf_pkg::ITEM_W-1:wlf_pkg::SRC_W];

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        belt_next     = belt_reg;
        budget_next   = budget_reg;
        status_next   = wlf_pkg::ST_DONE;
        refilled_next = 1'b0;
        omass_next    = '0;
        osrc_next     = '0;
        mem_we        = 1'b0;
        base_budget   = budget_reg;
        if (kind_reg == wlf_pkg::KIND_PUT)
        begin
            if ((count_reg < ring) && (put_sum <= {1'b0, limit_reg}))
            begin
                mem_we     = cmd.exec;
                tail_next  = tail_adv;
                count_next = count_reg + wlf_pkg::CNT_W'(1);
                belt_next  = put_sum[wlf_pkg::WT_W-1:0];
            end
            else
            begin
                status_next = wlf_pkg::ST_REFUSED;
            end
        end
        else if (count_reg == '0)
        begin
            status_next = wlf_pkg::ST_EMPTY;
        end
        else
        begin
            omass_next = head_mass;
            osrc_next  = rd_data_reg[wlf_pkg::SRC_W-1:0];
            if ((wlf_pkg::WT_W'(head_mass) <= budget_reg) ||
                (wlf_pkg::WT_W'(head_mass) <= cap_reg))
            begin
                if (wlf_pkg::WT_W'(head_mass) > budget_reg)
                begin
                    base_budget   = cap_reg;
                    refilled_next = 1'b1;
                end
                budget_next = base_budget - wlf_pkg::WT_W'(head_mass);
                head_next   = head_adv;
                count_next  = count_reg - wlf_pkg::CNT_W'(1);
                belt_next   = (belt_reg >= wlf_pkg::WT_W'(head_mass))
                            ? belt_reg - wlf_pkg::WT_W'(head_mass) : '0;
            end
            else
            begin
                status_next = wlf_pkg::ST_OVERSIZE;
            end
        end
    end

    // item store, head read registered every cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg] <= {mass_reg, src_reg};
        end
        rd_data_reg <= mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            belt_reg      <= '0;
            budget_reg    <= '0;
            slots_reg     <= wlf_pkg::SLOTS_RST;
            limit_reg     <= wlf_pkg::WT_LIMIT_RST;
            cap_reg       <= wlf_pkg::CAPACITY_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    wlf_pkg::CFG_SLOTS:    slots_reg <= cfg_data[wlf_pkg::CNT_W-1:0];
                    wlf_pkg::CFG_WT_LIMIT: limit_reg <= cfg_data;
                    wlf_pkg::CFG_CAPACITY: cap_reg   <= cfg_data;
                    default:               ;
                endcase
            end
            if (cmd.exec)
            begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                count_reg     <= count_next;
                belt_reg      <= belt_next;
                budget_reg    <= budget_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            mass_reg <= item_mass;
            src_reg  <= source_id;
        end
        if (cmd.exec)
        begin
            status_reg   <= status_next;
            refilled_reg <= refilled_next;
            omass_reg    <= omass_next;
            osrc_reg     <= osrc_next;
        end
    end

    assign sts.out_full    = out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign budget_refilled = refilled_reg;
    assign out_mass        = omass_reg;
    assign out_source      = osrc_reg;
    assign budget_left     = budget_reg;
    assign items_held      = count_reg;
    assign mass_held       = belt_reg;

endmodule

`default_nettype wire

>>> sv/weight_limited_fifo_with_consumer_budget_core.sv
// a request is captured into the request registers, executed in the exec state and
// its result registered; requests are handled one at a time, paced by the exec state,
// the registered read of the item store and the single result register
// a new request is taken only once the previous result has left
// reset: pointers, count, belt mass and budget clear, registers take defaults
// item store contents stay undefined until written
`default_nettype none

module weight_limited_fifo_with_consumer_budget_core #(
    parameter int DEPTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          kind,
    input  wire logic [wlf_pkg::MASS_W-1:0]    item_mass,
    input  wire logic [wlf_pkg::SRC_W-1:0]     source_id,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         status,
    output logic                               budget_refilled,
    output logic [wlf_pkg::MASS_W-1:0]         out_mass,
    output logic [wlf_pkg::SRC_W-1:0]          out_source,
    output logic [wlf_pkg::WT_W-1:0]           budget_left,
    output logic [wlf_pkg::CNT_W-1:0]          items_held,
    output logic [wlf_pkg::WT_W-1:0]           mass_held,
    input  wire logic                          cfg_write_en,
    input  wire logic [wlf_pkg::CFG_A_W-1:0]   cfg_index,
    input  wire logic [wlf_pkg::WT_W-1:0]      cfg_data
);

    wlf_pkg::ctrl_cmd_t cmd;
    wlf_pkg::dp_sts_t   sts;

    wlf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wlf_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .kind            (kind),
        .item_mass       (item_mass),
        .source_id       (source_id),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .budget_refilled (budget_refilled),
        .out_mass        (out_mass),
        .out_source      (out_source),
        .budget_left     (budget_left),
        .items_held      (items_held),
        .mass_held       (mass_held)
    );

endmodule

`default_nettype wire

>>> sv/wlf_checker.sv
// port level assertions for the weight limited fifo and their bind
`default_nettype none

module wlf_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [1:0] status,
    input  wire logic       budget_refilled,
    input  wire logic [4:0] items_held
);

    // one request in flight: never ready while a result waits
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("request taken while result pending");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid ##1 out_valid)
        else $error("result not shown two cycles after request");

    a_empty_take: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == wlf_pkg::ST_EMPTY) |->
        (items_held == '0 && !budget_refilled))
        else $error("empty take with items held or refill");

    a_refill_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && budget_refilled) |-> (status == wlf_pkg::ST_DONE))
        else $error("refill reported on a failed step");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status)))
        else $error("stalled result dropped or changed");

endmodule

bind weight_limited_fifo_with_consumer_budget_core wlf_checker u_wlf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .budget_refilled (budget_refilled),
    .items_held      (items_held)
);

`default_nettype wire
